FILE: rtl/sbus_pkg.sv
package sbus_pkg;

    localparam int CHAN_W       = 11;
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_IDX_W   = 4;

    localparam logic [7:0]            HEADER_BYTE  = 8'h0F;
    localparam logic [4:0]            PAYLOAD_LAST = 5'd22;
    localparam logic [4:0]            FLAGS_POS    = 5'd23;
    localparam logic [CHAN_IDX_W-1:0] LAST_CHANNEL = 4'd15;
    localparam logic [3:0]            BITS_LAST    = 4'd10;
    localparam logic [2:0]            SHIFT_LAST   = 3'd7;
    localparam logic [7:0]            COUNT_MAX    = 8'hFF;
    localparam int                    LOST_BIT     = 2;
    localparam int                    FAILSAFE_BIT = 3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_start;
    } in_t;

    typedef struct packed {
        logic [CHAN_IDX_W-1:0] channel_index;
        logic [CHAN_W-1:0]     channel_value;
        logic                  lost_frame;
        logic                  failsafe;
        logic                  last;
    } out_t;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_COLLECT,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_READ,
        ST_LOAD
    } state_t;

endpackage

FILE: rtl/sbus_ram.sv
module sbus_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sbus_frame_decoder_top.sv
// header, flags and ignored bytes are taken in the idle state; a payload byte is accepted,
// then shifted one bit a cycle into the channel register in ST_SHIFT
// the end byte drains 16 channel results from the channel ram, each read in ST_READ
// once the output slot is free and registered in ST_LOAD; the next byte is not taken
// until the last one is loaded; rst_n is asynchronous active low and clears the control
// state; the channel ram is not cleared, every entry is written before a read
module sbus_frame_decoder_top #(
    parameter int RECEIVE_BUFFER_BYTES = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sbus_pkg::in_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output sbus_pkg::out_t out_item
);

    localparam logic [7:0] BUF_LIMIT = 8'(RECEIVE_BUFFER_BYTES);

    sbus_pkg::state_t state_reg, state_next;
    sbus_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  burst_cnt_reg, burst_cnt_next;
    logic [1:0]  flags_reg, flags_next;
    logic [3:0]  bits_reg, bits_next;
    logic [sbus_pkg::CHAN_IDX_W-1:0] chan_cnt_reg, chan_cnt_next;
    logic [sbus_pkg::CHAN_IDX_W-1:0] emit_idx_reg, emit_idx_next;
    logic [sbus_pkg::CHAN_W-1:0]     acc_reg, acc_next;
    logic [7:0]  byte_sr_reg, byte_sr_next;
    logic [2:0]  shift_cnt_reg, shift_cnt_next;
    logic        out_valid_reg, out_valid_next;
    sbus_pkg::out_t out_reg, out_next;

    logic        in_fire;
    logic        restart;
    sbus_pkg::phase_t phase_eff;
    logic [4:0]  pos_inc;
    logic        slot_free;
    logic [sbus_pkg::CHAN_W-1:0] acc_shifted;

    logic        ram_we;
    logic        ram_re;
    logic [sbus_pkg::CHAN_W-1:0] ram_rdata;

    assign in_fire     = in_valid && in_ready;
    assign restart     = in_item.burst_start || (burst_cnt_reg >= BUF_LIMIT);
    assign phase_eff   = restart ? sbus_pkg::PH_HUNT : phase_reg;
    assign pos_inc     = pos_reg + 5'd1;
    assign slot_free   = !out_valid_reg || out_ready;
    assign acc_shifted = {byte_sr_reg[0], acc_reg[sbus_pkg::CHAN_W-1:1]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbus_pkg::ST_IDLE:
            begin
                if (in_valid && phase_eff == sbus_pkg::PH_COLLECT)
                begin
                    if (pos_inc <= sbus_pkg::PAYLOAD_LAST)
                    begin
                        state_next = sbus_pkg::ST_SHIFT;
                    end
                    else if (pos_inc != sbus_pkg::FLAGS_POS)
                    begin
                        state_next = sbus_pkg::ST_READ;
                    end
                end
            end
            sbus_pkg::ST_SHIFT:
            begin
                if (shift_cnt_reg == sbus_pkg::SHIFT_LAST)
                begin
                    state_next = sbus_pkg::ST_IDLE;
                end
            end
            sbus_pkg::ST_READ:
            begin
                if (slot_free)
                begin
                    state_next = sbus_pkg::ST_LOAD;
                end
            end
            sbus_pkg::ST_LOAD:
            begin
                if (emit_idx_reg == sbus_pkg::LAST_CHANNEL)
                begin
                    state_next = sbus_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = sbus_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = sbus_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_ready = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        case (state_reg)
            sbus_pkg::ST_IDLE:  in_ready = 1'b1;
            sbus_pkg::ST_SHIFT: ram_we   = (bits_reg == sbus_pkg::BITS_LAST);
            sbus_pkg::ST_READ:  ram_re   = slot_free;
            sbus_pkg::ST_LOAD:  ram_re   = 1'b0;
            default:            in_ready = 1'b0;
        endcase
    end

    // frame datapath
    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        burst_cnt_next = burst_cnt_reg;
        flags_next     = flags_reg;
        bits_next      = bits_reg;
        chan_cnt_next  = chan_cnt_reg;
        emit_idx_next  = emit_idx_reg;
        acc_next       = acc_reg;
        byte_sr_next   = byte_sr_reg;
        shift_cnt_next = shift_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        if (in_fire)
        begin
            if (restart)
            begin
                burst_cnt_next = 8'd1;
            end
            else if (burst_cnt_reg != sbus_pkg::COUNT_MAX)
            begin
                burst_cnt_next = burst_cnt_reg + 8'd1;
            end
            phase_next = phase_eff;
            case (phase_eff)
                sbus_pkg::PH_HUNT:
                begin
                    if (in_item.rx_byte == sbus_pkg::HEADER_BYTE)
                    begin
                        phase_next    = sbus_pkg::PH_COLLECT;
                        pos_next      = '0;
                        bits_next     = '0;
                        chan_cnt_next = '0;
                        flags_next    = '0;
                    end
                end
                sbus_pkg::PH_COLLECT:
                begin
                    pos_next = pos_inc;
                    if (pos_inc <= sbus_pkg::PAYLOAD_LAST)
                    begin
                        byte_sr_next   = in_item.rx_byte;
                        shift_cnt_next = '0;
                    end
                    else if (pos_inc == sbus_pkg::FLAGS_POS)
                    begin
                        flags_next = {in_item.rx_byte[sbus_pkg::FAILSAFE_BIT],
                                      in_item.rx_byte[sbus_pkg::LOST_BIT]};
                    end
                    else
                    begin
                        phase_next    = sbus_pkg::PH_DONE;
                        emit_idx_next = '0;
                    end
                end
                default:
                begin
                    phase_next = phase_eff;
                end
            endcase
        end

        // one payload bit a cycle, lsb first
        if (state_reg == sbus_pkg::ST_SHIFT)
        begin
            acc_next       = acc_shifted;
            byte_sr_next   = {1'b0, byte_sr_reg[7:1]};
            shift_cnt_next = shift_cnt_reg + 3'd1;
            if (bits_reg == sbus_pkg::BITS_LAST)
            begin
                bits_next     = '0;
                chan_cnt_next = chan_cnt_reg + 4'd1;
            end
            else
            begin
                bits_next = bits_reg + 4'd1;
            end
        end

        if (state_reg == sbus_pkg::ST_LOAD)
        begin
            out_valid_next         = 1'b1;
            out_next.channel_index = emit_idx_reg;
            out_next.channel_value = ram_rdata;
            out_next.lost_frame    = flags_reg[0];
            out_next.failsafe      = flags_reg[1];
            out_next.last          = (emit_idx_reg == sbus_pkg::LAST_CHANNEL);
            emit_idx_next          = emit_idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbus_pkg::ST_IDLE;
            phase_reg     <= sbus_pkg::PH_HUNT;
            pos_reg       <= '0;
            burst_cnt_reg <= '0;
            flags_reg     <= '0;
            bits_reg      <= '0;
            chan_cnt_reg  <= '0;
            emit_idx_reg  <= '0;
            shift_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            burst_cnt_reg <= burst_cnt_next;
            flags_reg     <= flags_next;
            bits_reg      <= bits_next;
            chan_cnt_reg  <= chan_cnt_next;
            emit_idx_reg  <= emit_idx_next;
            shift_cnt_reg <= shift_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        byte_sr_reg <= byte_sr_next;
        out_reg     <= out_next;
    end

    sbus_ram #(
        .WIDTH(sbus_pkg::CHAN_W),
        .DEPTH(sbus_pkg::NUM_CHANNELS)
    ) u_chan_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(chan_cnt_reg),
        .wdata(acc_shifted),
        .re   (ram_re),
        .raddr(emit_idx_reg),
        .rdata(ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule
